@@ rtl/core/psd_pkg.sv @@
// Shared types and constants for the Prufer sequence decoder.
// Used by every module of the block; depends on nothing.
package psd_pkg;

   localparam int LABEL_W = 6;
   localparam int LENGTH_W = 7;
   localparam int NODE_COUNT_W = 7;
   localparam logic [LABEL_W-1:0] COUNT_MAX = 6'd63;
   localparam logic [LENGTH_W-1:0] LENGTH_MAX = 7'd127;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_RUN = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_WR,
      ST_CHECK,
      ST_ERR_EMIT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_STEP_RD,
      ST_STEP_V,
      ST_STEP_EMIT,
      ST_FINAL
   } state_type;

   // Bookkeeping of the loaded sequence, as seen by the controller.
   typedef struct packed {
      logic [LENGTH_W-1:0] length;
      logic                has_room;
      logic                bad_label;
      logic [LABEL_W-1:0]  max_label;
   } seq_status_type;

   // Commands from the controller to the sequence store.
   typedef struct packed {
      logic load;
      logic clear;
      logic rd_en;
   } seq_ctrl_type;

endpackage

@@ rtl/core/prufer_sequence_decoder_unit.sv @@
// Prufer sequence decoder, top level. A load request reads the label's count, then writes it back incremented.
// A run makes one check, then for each sequence step reads the label and its count and emits an
// edge, with count probes of the leaf scan in between; one count memory read port serves both.
// A rejected run gives its result and then sweeps all MAX_NODES entries of the count memory to zero.
// Reset is synchronous; after it the count memory is cleared, during which no request is taken
// (configuration writes are always taken).
module prufer_sequence_decoder_unit #(
   parameter int MAX_NODES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [5:0] node_label, [7:6] zero
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [5:0] edge_leaf, [11:6] edge_other, [15:12] zero
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // [0] error
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);

   localparam int SEQ_DEPTH = MAX_NODES - 2;
   localparam int NODE_AW = $clog2(MAX_NODES);
   localparam int SEQ_AW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;

   logic [psd_pkg::NODE_COUNT_W-1:0] node_count_ff, node_count_in;
   psd_pkg::seq_status_type          seq_status;
   psd_pkg::seq_ctrl_type            seq_ctrl;
   logic [SEQ_AW-1:0]                seq_rd_addr;
   logic [psd_pkg::LABEL_W-1:0]      seq_rd_data;
   logic                             cnt_wr_en;
   logic [NODE_AW-1:0]               cnt_wr_addr;
   logic [psd_pkg::LABEL_W-1:0]      cnt_wr_data;
   logic                             cnt_rd_en;
   logic [NODE_AW-1:0]               cnt_rd_addr;
   logic [psd_pkg::LABEL_W-1:0]      cnt_rd_data;
   logic [psd_pkg::LABEL_W-1:0]      rsp_leaf;
   logic [psd_pkg::LABEL_W-1:0]      rsp_other;

   assign csr_ready = 1'b1;
   assign node_count_in = csr_valid ? csr_data : node_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= 7'd2;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   psd_seq_store #(
      .MAX_NODES (MAX_NODES),
      .SEQ_AW    (SEQ_AW)
   ) u_seq_store (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (seq_ctrl),
      .load_label (req_tdata[psd_pkg::LABEL_W-1:0]),
      .rd_addr    (seq_rd_addr),
      .rd_data    (seq_rd_data),
      .status     (seq_status)
   );

   psd_cnt_mem #(
      .DEPTH (MAX_NODES),
      .AW    (NODE_AW)
   ) u_cnt_mem (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   psd_decode_ctrl #(
      .MAX_NODES (MAX_NODES),
      .NODE_AW   (NODE_AW),
      .SEQ_AW    (SEQ_AW)
   ) u_decode_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_action  (req_tuser),
      .req_label   (req_tdata[psd_pkg::LABEL_W-1:0]),
      .req_ready   (req_tready),
      .node_count  (node_count_ff),
      .seq_status  (seq_status),
      .seq_ctrl    (seq_ctrl),
      .seq_rd_addr (seq_rd_addr),
      .seq_rd_data (seq_rd_data),
      .cnt_wr_en   (cnt_wr_en),
      .cnt_wr_addr (cnt_wr_addr),
      .cnt_wr_data (cnt_wr_data),
      .cnt_rd_en   (cnt_rd_en),
      .cnt_rd_addr (cnt_rd_addr),
      .cnt_rd_data (cnt_rd_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_leaf    (rsp_leaf),
      .rsp_other   (rsp_other),
      .rsp_last    (rsp_tlast),
      .rsp_error   (rsp_tuser)
   );

   assign rsp_tdata = {4'b0000, rsp_other, rsp_leaf};

endmodule

@@ rtl/core/psd_seq_store.sv @@
// Sequence store: label memory plus length, bad-label and maximum-label tracking.
// Depends on psd_pkg.
module psd_seq_store #(
   parameter int MAX_NODES = 64,
   parameter int SEQ_AW = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  psd_pkg::seq_ctrl_type           ctrl,
   input  logic [psd_pkg::LABEL_W-1:0]     load_label,
   input  logic [SEQ_AW-1:0]               rd_addr,
   output logic [psd_pkg::LABEL_W-1:0]     rd_data,
   output psd_pkg::seq_status_type         status
);

   localparam int SEQ_DEPTH = MAX_NODES - 2;

   logic [psd_pkg::LABEL_W-1:0]  seq_mem_ff [SEQ_DEPTH];
   logic [psd_pkg::LABEL_W-1:0]  rd_data_ff;
   logic [psd_pkg::LENGTH_W-1:0] length_ff, length_in;
   logic                         bad_ff, bad_in;
   logic [psd_pkg::LABEL_W-1:0]  max_ff, max_in;
   logic                         has_room;
   logic                         store_en;
   logic                         label_high;

   assign has_room = length_ff < psd_pkg::LENGTH_W'(SEQ_DEPTH);
   assign store_en = ctrl.load && has_room;
   assign label_high = {1'b0, load_label} >= psd_pkg::LENGTH_W'(MAX_NODES);

   always_comb begin
      length_in = length_ff;
      bad_in = bad_ff;
      max_in = max_ff;
      if (ctrl.clear) begin
         length_in = '0;
         bad_in = 1'b0;
         max_in = '0;
      end else if (ctrl.load) begin
         if (length_ff != psd_pkg::LENGTH_MAX) begin
            length_in = length_ff + 7'd1;
         end
         if (store_en) begin
            if (label_high) begin
               bad_in = 1'b1;
            end
            if (load_label > max_ff) begin
               max_in = load_label;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         bad_ff <= 1'b0;
         max_ff <= '0;
      end else begin
         length_ff <= length_in;
         bad_ff <= bad_in;
         max_ff <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         seq_mem_ff[length_ff[SEQ_AW-1:0]] <= load_label;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= seq_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign status.length = length_ff;
   assign status.has_room = has_room;
   assign status.bad_label = bad_ff;
   assign status.max_label = max_ff;

endmodule

@@ rtl/core/psd_cnt_mem.sv @@
// Occurrence count memory: one write port, one read port, registered read data.
// Depends on psd_pkg for the count width.
module psd_cnt_mem #(
   parameter int DEPTH = 64,
   parameter int AW = 6
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [psd_pkg::LABEL_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [psd_pkg::LABEL_W-1:0] rd_data
);

   logic [psd_pkg::LABEL_W-1:0] mem_ff [DEPTH];
   logic [psd_pkg::LABEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/psd_decode_ctrl.sv @@
// Decode controller: load sequencing, error check, leaf pointer scan, edge output register.
// Depends on psd_pkg; drives psd_seq_store and psd_cnt_mem.
module psd_decode_ctrl #(
   parameter int MAX_NODES = 64,
   parameter int NODE_AW = 6,
   parameter int SEQ_AW = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_action,
   input  logic [psd_pkg::LABEL_W-1:0]      req_label,
   output logic                             req_ready,
   input  logic [psd_pkg::NODE_COUNT_W-1:0] node_count,
   input  psd_pkg::seq_status_type          seq_status,
   output psd_pkg::seq_ctrl_type            seq_ctrl,
   output logic [SEQ_AW-1:0]                seq_rd_addr,
   input  logic [psd_pkg::LABEL_W-1:0]      seq_rd_data,
   output logic                             cnt_wr_en,
   output logic [NODE_AW-1:0]               cnt_wr_addr,
   output logic [psd_pkg::LABEL_W-1:0]      cnt_wr_data,
   output logic                             cnt_rd_en,
   output logic [NODE_AW-1:0]               cnt_rd_addr,
   input  logic [psd_pkg::LABEL_W-1:0]      cnt_rd_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [psd_pkg::LABEL_W-1:0]      rsp_leaf,
   output logic [psd_pkg::LABEL_W-1:0]      rsp_other,
   output logic                             rsp_last,
   output logic                             rsp_error
);

   localparam int W = psd_pkg::NODE_COUNT_W;

   psd_pkg::state_type          state_ff, state_in;
   logic [NODE_AW-1:0]          sweep_ff, sweep_in;
   logic [NODE_AW-1:0]          scan_ff, scan_in;
   logic [NODE_AW-1:0]          ptr_ff, ptr_in;
   logic [NODE_AW-1:0]          leaf_ff, leaf_in;
   logic [NODE_AW-1:0]          v_ff, v_in;
   logic [NODE_AW-1:0]          label_ff, label_in;
   logic                        count_ok_ff, count_ok_in;
   logic [W-1:0]                step_ff, step_in;
   logic                        out_valid_ff, out_valid_in;
   logic [psd_pkg::LABEL_W-1:0] out_leaf_ff, out_leaf_in;
   logic [psd_pkg::LABEL_W-1:0] out_other_ff, out_other_in;
   logic                        out_last_ff, out_last_in;
   logic                        out_error_ff, out_error_in;

   logic                        out_free;
   logic                        run_error;
   logic [W-1:0]                seq_len_needed;
   logic [psd_pkg::LABEL_W-1:0] cnt_dec;
   logic [W-1:0]                step_next;

   assign out_free = !out_valid_ff || rsp_ready;
   assign seq_len_needed = node_count - 7'd2;
   assign cnt_dec = cnt_rd_data - 6'd1;
   assign step_next = step_ff + 7'd1;

   // A run is rejected for a bad node count, a wrong length, a label beyond the
   // store's range, or a stored label at or above the node count.
   assign run_error = (node_count < 7'd2) || (node_count > W'(MAX_NODES))
      || (seq_status.length != seq_len_needed) || seq_status.bad_label
      || ((seq_status.length != '0) && ({1'b0, seq_status.max_label} >= node_count));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psd_pkg::ST_CLEAR;
         sweep_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      ptr_ff <= ptr_in;
      leaf_ff <= leaf_in;
      v_ff <= v_in;
      label_ff <= label_in;
      count_ok_ff <= count_ok_in;
      step_ff <= step_in;
      out_leaf_ff <= out_leaf_in;
      out_other_ff <= out_other_in;
      out_last_ff <= out_last_in;
      out_error_ff <= out_error_in;
   end

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      scan_in = scan_ff;
      ptr_in = ptr_ff;
      leaf_in = leaf_ff;
      v_in = v_ff;
      label_in = label_ff;
      count_ok_in = count_ok_ff;
      step_in = step_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_leaf_in = out_leaf_ff;
      out_other_in = out_other_ff;
      out_last_in = out_last_ff;
      out_error_in = out_error_ff;
      req_ready = 1'b0;
      seq_ctrl = '0;
      seq_rd_addr = step_ff[SEQ_AW-1:0];
      cnt_wr_en = 1'b0;
      cnt_wr_addr = sweep_ff;
      cnt_wr_data = '0;
      cnt_rd_en = 1'b0;
      cnt_rd_addr = scan_ff;

      unique case (state_ff)
         psd_pkg::ST_CLEAR: begin
            cnt_wr_en = 1'b1;
            sweep_in = NODE_AW'(sweep_ff + 1'b1);
            if (sweep_ff == NODE_AW'(MAX_NODES - 1)) begin
               sweep_in = '0;
               state_in = psd_pkg::ST_IDLE;
            end
         end
         psd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == psd_pkg::ACT_LOAD) begin
                  seq_ctrl.load = 1'b1;
                  // Read the label's count now; the increment is written next cycle.
                  cnt_rd_en = 1'b1;
                  cnt_rd_addr = req_label[NODE_AW-1:0];
                  label_in = req_label[NODE_AW-1:0];
                  count_ok_in = seq_status.has_room
                     && ({1'b0, req_label} < W'(MAX_NODES));
                  state_in = psd_pkg::ST_LOAD_WR;
               end else begin
                  state_in = psd_pkg::ST_CHECK;
               end
            end
         end
         psd_pkg::ST_LOAD_WR: begin
            cnt_wr_en = count_ok_ff;
            cnt_wr_addr = label_ff;
            cnt_wr_data = (cnt_rd_data == psd_pkg::COUNT_MAX) ? cnt_rd_data
                                                               : cnt_rd_data + 6'd1;
            state_in = psd_pkg::ST_IDLE;
         end
         psd_pkg::ST_CHECK: begin
            scan_in = '0;
            step_in = '0;
            state_in = run_error ? psd_pkg::ST_ERR_EMIT : psd_pkg::ST_SCAN_RD;
         end
         psd_pkg::ST_ERR_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_leaf_in = '0;
               out_other_in = '0;
               out_last_in = 1'b1;
               out_error_in = 1'b1;
               seq_ctrl.clear = 1'b1;
               sweep_in = '0;
               state_in = psd_pkg::ST_CLEAR;
            end
         end
         psd_pkg::ST_SCAN_RD: begin
            cnt_rd_en = 1'b1;
            state_in = psd_pkg::ST_SCAN_CHK;
         end
         psd_pkg::ST_SCAN_CHK: begin
            if (cnt_rd_data == '0) begin
               leaf_in = scan_ff;
               ptr_in = scan_ff;
               state_in = (step_ff == seq_len_needed) ? psd_pkg::ST_FINAL
                                                      : psd_pkg::ST_STEP_RD;
            end else begin
               scan_in = NODE_AW'(scan_ff + 1'b1);
               state_in = psd_pkg::ST_SCAN_RD;
            end
         end
         psd_pkg::ST_STEP_RD: begin
            seq_ctrl.rd_en = 1'b1;
            state_in = psd_pkg::ST_STEP_V;
         end
         psd_pkg::ST_STEP_V: begin
            v_in = seq_rd_data[NODE_AW-1:0];
            cnt_rd_en = 1'b1;
            cnt_rd_addr = seq_rd_data[NODE_AW-1:0];
            state_in = psd_pkg::ST_STEP_EMIT;
         end
         psd_pkg::ST_STEP_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_leaf_in = psd_pkg::LABEL_W'(leaf_ff);
               out_other_in = psd_pkg::LABEL_W'(v_ff);
               out_last_in = 1'b0;
               out_error_in = 1'b0;
               cnt_wr_en = 1'b1;
               cnt_wr_addr = v_ff;
               cnt_wr_data = cnt_dec;
               step_in = step_next;
               // A node that has just become a leaf below the pointer is the
               // smallest leaf; otherwise the scan carries on above the pointer.
               if ((cnt_dec == '0) && (v_ff < ptr_ff)) begin
                  leaf_in = v_ff;
                  state_in = (step_next == seq_len_needed) ? psd_pkg::ST_FINAL
                                                           : psd_pkg::ST_STEP_RD;
               end else begin
                  scan_in = NODE_AW'(ptr_ff + 1'b1);
                  state_in = psd_pkg::ST_SCAN_RD;
               end
            end
         end
         psd_pkg::ST_FINAL: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_leaf_in = psd_pkg::LABEL_W'(leaf_ff);
               out_other_in = psd_pkg::LABEL_W'(node_count - 7'd1);
               out_last_in = 1'b1;
               out_error_in = 1'b0;
               seq_ctrl.clear = 1'b1;
               state_in = psd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = psd_pkg::ST_CLEAR;
            sweep_in = '0;
         end
      endcase
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_leaf = out_leaf_ff;
   assign rsp_other = out_other_ff;
   assign rsp_last = out_last_ff;
   assign rsp_error = out_error_ff;

endmodule
